/* rtl/qrap_pkg.sv */
// Shared constants and index helpers for the pivot rotation datapath.
// No dependencies; imported by qrap_cross and the top level.
`default_nettype none

package qrap_pkg;

    // Number of vector components handled side by side.
    localparam int AXES = 3;

    // Cyclic successor of an axis index (x -> y -> z -> x).
    function automatic int axis_next(input int idx);
        int nxt;
        nxt = (idx == AXES - 1) ? 0 : idx + 1;
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* rtl/qrap_cross.sv */
// Pipelined rounded cross product c = a x b, three register stages.
// Every product is rounded to nearest and scaled down by 2^(QW-1).
// Depends on qrap_pkg.
`default_nettype none

module qrap_cross #(
    parameter int QW = 16,
    parameter int BW = 25
) (
    input  wire logic                        i_clk,
    input  wire logic signed [QW-1:0]        i_a [qrap_pkg::AXES],
    input  wire logic signed [BW-1:0]        i_b [qrap_pkg::AXES],
    output logic signed [QW+BW-(QW-1)+1:0]   o_c [qrap_pkg::AXES]
);
    import qrap_pkg::*;

    localparam int F  = QW - 1;
    localparam int PW = QW + BW;
    localparam int RW = PW - F + 1;
    localparam int CW = RW + 1;
    localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (F - 1);

    logic signed [PW-1:0] r_pj [AXES];
    logic signed [PW-1:0] r_pk [AXES];
    logic signed [RW-1:0] r_rj [AXES];
    logic signed [RW-1:0] r_rk [AXES];
    logic signed [CW-1:0] r_c  [AXES];

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        localparam int J = axis_next(i);
        localparam int K = axis_next(J);

        logic signed [PW:0] n_sj;
        logic signed [PW:0] n_sk;

        // Adding one half and dropping F bits rounds to nearest, with ties upward.
        assign n_sj = {r_pj[i][PW-1], r_pj[i]} + HALF;
        assign n_sk = {r_pk[i][PW-1], r_pk[i]} + HALF;

        always_ff @(posedge i_clk) begin
            r_pj[i] <= PW'(i_a[J]) * PW'(i_b[K]);
            r_pk[i] <= PW'(i_a[K]) * PW'(i_b[J]);
            r_rj[i] <= n_sj[PW:F];
            r_rk[i] <= n_sk[PW:F];
            r_c[i]  <= CW'(r_rj[i]) - CW'(r_rk[i]);
        end

        assign o_c[i] = r_c[i];
    end

endmodule

`default_nettype wire

/* rtl/quaternion_rotate_about_pivot_top.sv */
// Top level: rotates a point about a pivot by a fixed-point quaternion.
// Depends on qrap_pkg and qrap_cross.
//
//   channel   | handshake        | payload
//   ----------+------------------+--------------------------------------------
//   request   | start / busy     | i_quat_{x,y,z,w}, i_point_{x,y,z}, i_pivot_{x,y,z}
//   result    | o_strobe         | o_rotated_{x,y,z}, o_saturated
//
// A request is taken in every cycle; busy stays low. Each result passes through
// the nine register stages of the datapath (difference, two three-stage cross
// products, sum, saturation).
// Reset clears only the valid bits that travel with the data.
// The receiver takes every strobed result, so nothing in the pipe ever waits.
`default_nettype none

module quaternion_rotate_about_pivot_top #(
    parameter int COORD_BITS = 24,
    parameter int QUAT_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [QUAT_BITS-1:0]  i_quat_x,
    input  wire logic signed [QUAT_BITS-1:0]  i_quat_y,
    input  wire logic signed [QUAT_BITS-1:0]  i_quat_z,
    input  wire logic signed [QUAT_BITS-1:0]  i_quat_w,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    input  wire logic signed [COORD_BITS-1:0] i_point_z,
    input  wire logic signed [COORD_BITS-1:0] i_pivot_x,
    input  wire logic signed [COORD_BITS-1:0] i_pivot_y,
    input  wire logic signed [COORD_BITS-1:0] i_pivot_z,
    output logic                              o_strobe,
    output logic signed [COORD_BITS-1:0]      o_rotated_x,
    output logic signed [COORD_BITS-1:0]      o_rotated_y,
    output logic signed [COORD_BITS-1:0]      o_rotated_z,
    output logic                              o_saturated
);
    import qrap_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int Q    = QUAT_BITS;
    localparam int F    = Q - 1;
    localparam int DW   = C + 1;               // point - pivot
    localparam int UW   = Q + DW - F + 2;      // u = qv x d
    localparam int U2W  = UW + 1;              // 2u
    localparam int SW   = Q + U2W - F + 2;     // qv x 2u
    localparam int WPW  = Q + U2W;             // w * 2u
    localparam int WTW  = WPW - F + 1;         // rounded w term
    localparam int RSW  = C + 9;               // final sum before clipping
    localparam int NSTG = 9;
    localparam int QDLY = 4;                   // stage 1 to stage 4
    localparam int PDLY = 7;                   // stage 1 to stage 7
    localparam logic signed [WPW:0]   HALF = (WPW + 1)'(1) << (F - 1);
    localparam logic signed [RSW-1:0] HI   = (RSW'(1) << (C - 1)) - RSW'(1);
    localparam logic signed [RSW-1:0] LO   = -HI - RSW'(1);

    logic                   r_vld [NSTG];
    logic signed [Q-1:0]    r_q   [QDLY][AXES];
    logic signed [Q-1:0]    r_w   [QDLY];
    logic signed [C-1:0]    r_pt  [PDLY][AXES];
    logic signed [DW-1:0]   r_d   [AXES];
    logic signed [WPW-1:0]  r_wp  [AXES];
    logic signed [WTW-1:0]  r_wt6 [AXES];
    logic signed [WTW-1:0]  r_wt7 [AXES];
    logic signed [RSW-1:0]  r_sum [AXES];
    logic signed [C-1:0]    r_rot [AXES];
    logic                   r_sat;

    logic signed [Q-1:0]    w_qin  [AXES];
    logic signed [C-1:0]    w_ptin [AXES];
    logic signed [C-1:0]    w_pvin [AXES];
    logic signed [UW-1:0]   w_u    [AXES];
    logic signed [U2W-1:0]  w_u2   [AXES];
    logic signed [SW-1:0]   w_s    [AXES];
    logic signed [C-1:0]    n_rot  [AXES];
    logic [AXES-1:0]        n_clip;

    assign busy = 1'b0;

    assign w_qin[0]  = i_quat_x;
    assign w_qin[1]  = i_quat_y;
    assign w_qin[2]  = i_quat_z;
    assign w_ptin[0] = i_point_x;
    assign w_ptin[1] = i_point_y;
    assign w_ptin[2] = i_point_z;
    assign w_pvin[0] = i_pivot_x;
    assign w_pvin[1] = i_pivot_y;
    assign w_pvin[2] = i_pivot_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start & ~busy;
            for (int s = 1; s < NSTG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1 and the delay lines that keep q, w and the point aligned.
    always_ff @(posedge i_clk) begin
        r_w[0] <= i_quat_w;
        for (int s = 1; s < QDLY; s++) begin
            r_w[s] <= r_w[s-1];
        end
        for (int i = 0; i < AXES; i++) begin
            r_q[0][i]  <= w_qin[i];
            r_pt[0][i] <= w_ptin[i];
            r_d[i]     <= DW'(w_ptin[i]) - DW'(w_pvin[i]);
            for (int s = 1; s < QDLY; s++) begin
                r_q[s][i] <= r_q[s-1][i];
            end
            for (int s = 1; s < PDLY; s++) begin
                r_pt[s][i] <= r_pt[s-1][i];
            end
        end
    end

    // Stages 2 to 4: u = qv x d.
    qrap_cross #(
        .QW (Q),
        .BW (DW)
    ) u_cross_d (
        .i_clk (i_clk),
        .i_a   (r_q[0]),
        .i_b   (r_d),
        .o_c   (w_u)
    );

    for (genvar i = 0; i < AXES; i++) begin : g_u2
        assign w_u2[i] = {w_u[i], 1'b0};
    end

    // Stages 5 to 7: qv x 2u, alongside the w term.
    qrap_cross #(
        .QW (Q),
        .BW (U2W)
    ) u_cross_u (
        .i_clk (i_clk),
        .i_a   (r_q[QDLY-1]),
        .i_b   (w_u2),
        .o_c   (w_s)
    );

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        logic signed [WPW:0] n_wr;

        assign n_wr = {r_wp[i][WPW-1], r_wp[i]} + HALF;

        always_comb begin
            n_clip[i] = 1'b0;
            n_rot[i]  = r_sum[i][C-1:0];
            if (r_sum[i] > HI) begin
                n_clip[i] = 1'b1;
                n_rot[i]  = HI[C-1:0];
            end else if (r_sum[i] < LO) begin
                n_clip[i] = 1'b1;
                n_rot[i]  = LO[C-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_wp[i]  <= WPW'(r_w[QDLY-1]) * WPW'(w_u2[i]);
            r_wt6[i] <= n_wr[WPW:F];
            r_wt7[i] <= r_wt6[i];
            // pivot + d is the point itself.
            r_sum[i] <= RSW'(r_pt[PDLY-1][i]) - RSW'(r_wt7[i]) + RSW'(w_s[i]);
            r_rot[i] <= n_rot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= |n_clip;
    end

    assign o_strobe    = r_vld[NSTG-1];
    assign o_rotated_x = r_rot[0];
    assign o_rotated_y = r_rot[1];
    assign o_rotated_z = r_rot[2];
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

/* tb/quaternion_rotate_about_pivot_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_rotate_about_pivot_top: directed and random requests
// with random gaps. Each rotation is predicted in fixed point and checked field by field.
// Depends on qrap_pkg and the block's RTL.

module quaternion_rotate_about_pivot_top_tb;
    import qrap_pkg::*;

    localparam int COORD_BITS = 24;
    localparam int QUAT_BITS  = 16;
    localparam int FRAC_SH    = QUAT_BITS - 1;
    localparam int LATENCY    = 9;
    localparam int RANDOM_REQS = 1500;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef logic signed [QUAT_BITS-1:0]  t_quat;
    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_quat  qx, qy, qz, qw;
        t_coord pt_x, pt_y, pt_z;
        t_coord pv_x, pv_y, pv_z;
    } t_rot_req;

    typedef struct packed {
        t_coord x, y, z;
        logic   sat;
    } t_rot_res;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    t_quat  i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    t_coord i_point_x = '0, i_point_y = '0, i_point_z = '0;
    t_coord i_pivot_x = '0, i_pivot_y = '0, i_pivot_z = '0;
    logic   busy, o_strobe, o_saturated;
    t_coord o_rotated_x, o_rotated_y, o_rotated_z;

    t_rot_req pending_reqs[$];
    t_rot_res rotations_due[$];
    logic     req_taken = 1'b0;
    int       fault_count = 0;
    int       burst_left = 0;

    quaternion_rotate_about_pivot_top #(
        .COORD_BITS(COORD_BITS),
        .QUAT_BITS (QUAT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_quat_x   (i_quat_x),
        .i_quat_y   (i_quat_y),
        .i_quat_z   (i_quat_z),
        .i_quat_w   (i_quat_w),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_point_z  (i_point_z),
        .i_pivot_x  (i_pivot_x),
        .i_pivot_y  (i_pivot_y),
        .i_pivot_z  (i_pivot_z),
        .o_strobe   (o_strobe),
        .o_rotated_x(o_rotated_x),
        .o_rotated_y(o_rotated_y),
        .o_rotated_z(o_rotated_z),
        .o_saturated(o_saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Scale a product down by 2^FRAC_SH, rounding to nearest with ties toward plus infinity.
    function automatic longint round_q15(input longint p);
        return (p + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
    endfunction

    function automatic t_rot_res rotate_about_pivot(input t_rot_req r);
        longint   qv[AXES];
        longint   pv[AXES];
        longint   pt[AXES];
        longint   d[AXES];
        longint   u[AXES];
        longint   s[AXES];
        longint   w;
        longint   sum;
        t_coord   clipped[AXES];
        logic     sat;
        int       i, j, k;
        t_rot_res res;
        qv[0] = r.qx;   qv[1] = r.qy;   qv[2] = r.qz;   w = r.qw;
        pt[0] = r.pt_x; pt[1] = r.pt_y; pt[2] = r.pt_z;
        pv[0] = r.pv_x; pv[1] = r.pv_y; pv[2] = r.pv_z;
        sat = 1'b0;
        for (i = 0; i < AXES; i++)
            d[i] = pt[i] - pv[i];
        for (i = 0; i < AXES; i++) begin
            j = (i + 1) % AXES;
            k = (i + 2) % AXES;
            u[i] = round_q15(qv[j] * d[k]) - round_q15(qv[k] * d[j]);
        end
        for (i = 0; i < AXES; i++) begin
            j = (i + 1) % AXES;
            k = (i + 2) % AXES;
            s[i] = round_q15(2 * qv[j] * u[k]) - round_q15(2 * qv[k] * u[j]);
        end
        // The w term is subtracted, which rotates by the conjugate quaternion.
        for (i = 0; i < AXES; i++) begin
            sum = pv[i] + d[i] - round_q15(2 * w * u[i]) + s[i];
            if (sum > COORD_MAX) begin
                sum = COORD_MAX;
                sat = 1'b1;
            end else if (sum < COORD_MIN) begin
                sum = COORD_MIN;
                sat = 1'b1;
            end
            clipped[i] = t_coord'(sum);
        end
        res = {clipped[0], clipped[1], clipped[2], sat};
        return res;
    endfunction

    function automatic t_rot_req mk_req(input int qx, qy, qz, qw,
                                        input int px, py, pz, vx, vy, vz);
        t_rot_req r;
        r = {t_quat'(qx), t_quat'(qy), t_quat'(qz), t_quat'(qw),
             t_coord'(px), t_coord'(py), t_coord'(pz),
             t_coord'(vx), t_coord'(vy), t_coord'(vz)};
        return r;
    endfunction

    function automatic t_quat edge_quat();
        case ($urandom_range(0, 4))
            0: return t_quat'(-32768);
            1: return t_quat'(32767);
            2: return t_quat'(0);
            3: return t_quat'(-1);
            default: return t_quat'(1);
        endcase
    endfunction

    function automatic t_coord edge_coord();
        case ($urandom_range(0, 4))
            0: return t_coord'(COORD_MIN);
            1: return t_coord'(COORD_MAX);
            2: return t_coord'(0);
            3: return t_coord'(-1);
            default: return t_coord'(1);
        endcase
    endfunction

    // Half unit quaternions, points mostly near their pivot, plus full-range and edge values.
    function automatic t_rot_req random_req();
        t_rot_req r;
        real      a[4];
        real      norm;
        int       i, qkind, pkind, base;
        qkind = $urandom_range(0, 9);
        pkind = $urandom_range(0, 9);
        if (qkind <= 4) begin
            norm = 0.0;
            for (i = 0; i < 4; i++) begin
                a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
                norm = norm + a[i] * a[i];
            end
            norm = $sqrt(norm);
            if (norm < 1.0) begin
                a[3] = 1.0;
                norm = 1.0;
            end
            r.qx = t_quat'($rtoi(a[0] / norm * 32767.0));
            r.qy = t_quat'($rtoi(a[1] / norm * 32767.0));
            r.qz = t_quat'($rtoi(a[2] / norm * 32767.0));
            r.qw = t_quat'($rtoi(a[3] / norm * 32767.0));
        end else if (qkind <= 7) begin
            r.qx = t_quat'($urandom);
            r.qy = t_quat'($urandom);
            r.qz = t_quat'($urandom);
            r.qw = t_quat'($urandom);
        end else begin
            r.qx = edge_quat();
            r.qy = edge_quat();
            r.qz = edge_quat();
            r.qw = edge_quat();
        end
        if (pkind <= 5) begin
            base = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            r.pv_x = t_coord'(base);
            r.pt_x = t_coord'(base + int'($urandom_range(0, 2 ** 17)) - 2 ** 16);
            base = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            r.pv_y = t_coord'(base);
            r.pt_y = t_coord'(base + int'($urandom_range(0, 2 ** 17)) - 2 ** 16);
            base = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            r.pv_z = t_coord'(base);
            r.pt_z = t_coord'(base + int'($urandom_range(0, 2 ** 17)) - 2 ** 16);
        end else if (pkind <= 8) begin
            r.pt_x = t_coord'($urandom);
            r.pt_y = t_coord'($urandom);
            r.pt_z = t_coord'($urandom);
            r.pv_x = t_coord'($urandom);
            r.pv_y = t_coord'($urandom);
            r.pv_z = t_coord'($urandom);
        end else begin
            r.pt_x = edge_coord();
            r.pt_y = edge_coord();
            r.pt_z = edge_coord();
            r.pv_x = edge_coord();
            r.pv_y = edge_coord();
            r.pv_z = edge_coord();
        end
        return r;
    endfunction

    // Gap before the next request; now and then a run of back-to-back requests.
    function automatic int idle_cycles();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            burst_left = $urandom_range(20, 60);
        return $urandom_range(0, 8);
    endfunction

    task automatic drive_request(input t_rot_req r);
        i_quat_x  <= r.qx;
        i_quat_y  <= r.qy;
        i_quat_z  <= r.qz;
        i_quat_w  <= r.qw;
        i_point_x <= r.pt_x;
        i_point_y <= r.pt_y;
        i_point_z <= r.pt_z;
        i_pivot_x <= r.pv_x;
        i_pivot_y <= r.pv_y;
        i_pivot_z <= r.pv_z;
    endtask

    task automatic report_fault(input string what, input t_rot_res want, input t_rot_res got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: expected (%0d, %0d, %0d, sat %0b) got (%0d, %0d, %0d, sat %0b)",
                     $realtime, what, want.x, want.y, want.z, want.sat,
                     got.x, got.y, got.z, got.sat);
    endtask

    always @(negedge i_clk) begin : request_driver
        t_rot_req nxt;
        int       gap_left;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else if (!start || req_taken) begin
            if (gap_left == 0 && pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                drive_request(nxt);
                start <= 1'b1;
                gap_left = idle_cycles();
            end else begin
                if (gap_left != 0)
                    gap_left--;
                start <= 1'b0;
                // Idle cycles carry junk on the payload ports; the block must ignore it.
                drive_request(random_req());
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_rot_res got;
        t_rot_res want;
        req_taken <= start && (busy === 1'b0);
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                got = {o_rotated_x, o_rotated_y, o_rotated_z, o_saturated};
                if (rotations_due.size() == 0) begin
                    report_fault("unexpected result", '0, got);
                end else begin
                    want = rotations_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                        || got.sat !== want.sat || o_strobe !== 1'b1)
                        report_fault("result mismatch", want, got);
                end
            end
            if (start && busy === 1'b0)
                rotations_due.push_back(rotate_about_pivot({i_quat_x, i_quat_y, i_quat_z,
                    i_quat_w, i_point_x, i_point_y, i_point_z, i_pivot_x, i_pivot_y,
                    i_pivot_z}));
        end
    end

    initial begin : main_sequence
        int guard;
        int n;
        // Identity and zero quaternions, with and without a pivot offset.
        pending_reqs.push_back(mk_req(0, 0, 0, 32767, 1000, -2000, 3000, 0, 0, 0));
        pending_reqs.push_back(mk_req(0, 0, 0, 32767, 5000, 7000, -9000, 1234, -4321, 77));
        pending_reqs.push_back(mk_req(0, 0, 0, 0, 123456, -654321, 42, -1000, 2000, -3000));
        // Point on the pivot: the result is the pivot whatever the quaternion.
        pending_reqs.push_back(mk_req(12345, -23456, 30000, -5000,
                                      777777, -888888, 999999, 777777, -888888, 999999));
        // Quarter turn about z, half turn about x, and the negated identity.
        pending_reqs.push_back(mk_req(0, 0, 23170, 23170, 25600, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(32767, 0, 0, 0, 0, 25600, -12800, 0, 0, 0));
        pending_reqs.push_back(mk_req(0, 0, 0, -32768, 8388607, 0, -8388608, 0, 0, 0));
        // Extreme quaternions and coordinates, driving the sums into clipping.
        pending_reqs.push_back(mk_req(-32768, -32768, -32768, -32768,
                                      8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
        pending_reqs.push_back(mk_req(32767, 32767, 32767, 32767,
                                      -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        pending_reqs.push_back(mk_req(-32768, -32768, -32768, -32768,
                                      -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        pending_reqs.push_back(mk_req(32767, 32767, 32767, 32767,
                                      8388607, -8388608, 8388607, -8388608, 8388607, -8388608));
        pending_reqs.push_back(mk_req(-32768, 0, 0, 32767, 0, 8388607, -8388608, 0, 0, 0));
        pending_reqs.push_back(mk_req(0, -32768, 0, 32767, -8388608, 0, 8388607, 0, 0, 0));
        pending_reqs.push_back(mk_req(0, 0, -32768, 32767, 8388607, -8388608, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(32767, -32768, 32767, -32768,
                                      8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        pending_reqs.push_back(mk_req(-32768, 32767, -32768, 32767,
                                      -8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
        // A quaternion far from unit length scales the offset.
        pending_reqs.push_back(mk_req(20000, 20000, 20000, 20000,
                                      1048576, -524288, 262144, 0, 0, 0));
        pending_reqs.push_back(mk_req(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0));
        // Products that land exactly on a rounding tie, both signs.
        pending_reqs.push_back(mk_req(1, 1, 1, 1, 16384, -16384, 16384, 0, 0, 0));
        pending_reqs.push_back(mk_req(-1, 1, -1, 1, -16384, 16384, 49152, 0, 0, 0));
        for (n = 0; n < RANDOM_REQS; n++)
            pending_reqs.push_back(random_req());

        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start)
            @(posedge i_clk);
        guard = 0;
        while (rotations_due.size() != 0 && guard < 20 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (rotations_due.size() != 0) begin
            if (fault_count < 10)
                $display("%0t: %0d results never arrived", $realtime, rotations_due.size());
            fault_count += rotations_due.size();
        end
        if (fault_count == 0) begin
            $display("quaternion_rotate_about_pivot_top_tb: clean");
        end else begin
            $display("quaternion_rotate_about_pivot_top_tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("quaternion_rotate_about_pivot_top_tb: errors");
        $finish;
    end

endmodule
